// ----- hw/rtl/ipv4p_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 dotted-text parser.
// No dependencies; imported by every module of the block.
package ipv4p_pkg;

   // Parse phase within the current part
   typedef enum logic [1:0] {
      PH_START      = 2'd0,
      PH_AFTER_ZERO = 2'd1,
      PH_AFTER_0X   = 2'd2,
      PH_DIGITS     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
   localparam logic [31:0] DEC_MAX_DIV = ALL_ONES / 32'd10;
   localparam logic [31:0] OCT_MAX_DIV = ALL_ONES / 32'd8;
   localparam logic [31:0] HEX_MAX_DIV = ALL_ONES / 32'd16;
   localparam logic [31:0] BYTE_MAX    = 32'h0000_00ff;
   localparam logic [2:0]  MAX_PARTS   = 3'd4;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_PERIOD = 8'h2e;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_LX     = 8'h78;

   // Outcome of adding one digit to the current part
   typedef struct packed {
      logic        ok;
      logic [31:0] value;
   } acc_result_type;

   // One parse result, produced on the terminating NUL
   typedef struct packed {
      logic        valid_res;
      logic [31:0] address;
   } parse_result_type;

endpackage

// ----- hw/rtl/ipv4p_digit_acc.sv -----
`timescale 1ns / 1ps
// Digit decode and multiply-add of one character into the current part value.
// Depends on ipv4p_pkg.
module ipv4p_digit_acc
   import ipv4p_pkg::*;
(
   input  logic [7:0]     char_code,
   input  base_type       base,
   input  logic [31:0]    cur_value,
   output acc_result_type acc
);

   logic [7:0]  off;
   logic [3:0]  digit;
   logic        is_digit;
   logic        fits_base;
   logic [31:0] max_div;
   logic [35:0] cur_wide;
   logic [35:0] product;
   logic [35:0] sum;

   always_comb begin
      off      = 8'd0;
      digit    = 4'd0;
      is_digit = 1'b0;
      if (char_code >= CHAR_0 && char_code <= CHAR_9) begin
         off      = char_code - CHAR_0;
         digit    = off[3:0];
         is_digit = 1'b1;
      end else if (char_code >= CHAR_LA && char_code <= CHAR_LF) begin
         off      = char_code - CHAR_LA;
         digit    = off[3:0] + 4'd10;
         is_digit = 1'b1;
      end else if (char_code >= CHAR_UA && char_code <= CHAR_UF) begin
         off      = char_code - CHAR_UA;
         digit    = off[3:0] + 4'd10;
         is_digit = 1'b1;
      end
   end

   assign cur_wide = {4'd0, cur_value};

   always_comb begin
      case (base)
         BASE_OCT: begin
            max_div   = OCT_MAX_DIV;
            fits_base = (digit < 4'd8);
            product   = cur_wide << 3;
         end
         BASE_HEX: begin
            max_div   = HEX_MAX_DIV;
            fits_base = 1'b1;
            product   = cur_wide << 4;
         end
         default: begin
            max_div   = DEC_MAX_DIV;
            fits_base = (digit < 4'd10);
            product   = (cur_wide << 3) + (cur_wide << 1);
         end
      endcase
   end

   assign sum       = product + {32'd0, digit};
   assign acc.ok    = is_digit && fits_base && (cur_value <= max_div) && (sum[35:32] == 4'd0);
   assign acc.value = sum[31:0];

endmodule

// ----- hw/rtl/ipv4p_parse_fsm.sv -----
`timescale 1ns / 1ps
// Parse state machine: phase, base, part count, part bytes and error flag.
// Depends on ipv4p_pkg and ipv4p_digit_acc.
module ipv4p_parse_fsm
   import ipv4p_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       char_code,
   output parse_result_type result
);

   phase_type   phase_ff, phase_in;
   base_type    base_ff, base_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] cur_ff, cur_in;
   logic [7:0]  bytes_ff [3];
   logic [7:0]  bytes_in [3];
   logic        err_ff, err_in;

   base_type       acc_base;
   logic [31:0]    acc_cur;
   acc_result_type acc;
   logic           is_nul;
   logic           is_period;
   logic           close_part;
   logic [1:0]     close_idx;
   logic [31:0]    asm_addr;
   logic           asm_fit;

   assign is_nul    = (char_code == CHAR_NUL);
   assign is_period = (char_code == CHAR_PERIOD);

   // A new part starts from zero in decimal
   assign acc_base = (phase_ff == PH_START) ? BASE_DEC : base_ff;
   assign acc_cur  = (phase_ff == PH_START) ? 32'd0 : cur_ff;

   ipv4p_digit_acc u_acc (
      .char_code (char_code),
      .base      (acc_base),
      .cur_value (acc_cur),
      .acc       (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         base_ff  <= BASE_DEC;
         count_ff <= 3'd0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      bytes_ff <= bytes_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      base_in    = base_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      err_in     = err_ff;
      close_part = 1'b0;
      close_idx  = count_ff[1:0] - 2'd1;

      if (step && is_nul) begin
         phase_in = PH_START;
         base_in  = BASE_DEC;
         count_in = 3'd0;
         cur_in   = 32'd0;
         err_in   = 1'b0;
      end else if (step && !err_ff) begin
         case (phase_ff)
            PH_START: begin
               if (count_ff >= MAX_PARTS) begin
                  err_in = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
                  cur_in   = 32'd0;
                  if (char_code == CHAR_0) begin
                     base_in  = BASE_OCT;
                     phase_in = PH_AFTER_ZERO;
                  end else if (acc.ok) begin
                     base_in  = BASE_DEC;
                     cur_in   = acc.value;
                     phase_in = PH_DIGITS;
                  end else begin
                     err_in = 1'b1;
                  end
               end
            end
            PH_AFTER_ZERO: begin
               if (char_code == CHAR_LX) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_AFTER_0X;
               end else if (is_period) begin
                  close_part = 1'b1;
               end else if (acc.ok) begin
                  cur_in   = acc.value;
                  phase_in = PH_DIGITS;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_AFTER_0X: begin
               if (!is_period && acc.ok) begin
                  cur_in   = acc.value;
                  phase_in = PH_DIGITS;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (is_period) begin
                  close_part = 1'b1;
               end else if (acc.ok) begin
                  cur_in = acc.value;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase

         // A closed part is never the last one, so it must fit in a byte
         if (close_part) begin
            phase_in = PH_START;
            if (cur_ff > BYTE_MAX) begin
               err_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bytes_in[i] = bytes_ff[i];
         if (close_part && !count_ff[2] && close_idx == 2'(i)) begin
            bytes_in[i] = cur_ff[7:0];
         end
      end
   end

   // Last part fills the remaining low bits
   always_comb begin
      case (count_ff)
         3'd1: begin
            asm_addr = cur_ff;
            asm_fit  = 1'b1;
         end
         3'd2: begin
            asm_addr = {bytes_ff[0], cur_ff[23:0]};
            asm_fit  = (cur_ff[31:24] == 8'd0);
         end
         3'd3: begin
            asm_addr = {bytes_ff[0], bytes_ff[1], cur_ff[15:0]};
            asm_fit  = (cur_ff[31:16] == 16'd0);
         end
         3'd4: begin
            asm_addr = {bytes_ff[0], bytes_ff[1], bytes_ff[2], cur_ff[7:0]};
            asm_fit  = (cur_ff[31:8] == 24'd0);
         end
         default: begin
            asm_addr = 32'd0;
            asm_fit  = 1'b0;
         end
      endcase
   end

   assign result.valid_res = !err_ff && (phase_ff != PH_START) && asm_fit;
   assign result.address   = result.valid_res ? asm_addr : 32'd0;

   a_nul_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_nul |=> phase_ff == PH_START && count_ff == 3'd0 && !err_ff)
      else $error("parser state not cleared after end of string");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_START |-> count_ff != 3'd0 && count_ff <= MAX_PARTS)
      else $error("part count out of range inside a part");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !result.valid_res |-> result.address == 32'd0)
      else $error("invalid result carries a nonzero address");

endmodule

// ----- hw/rtl/ipv4_dotted_text_parser.sv -----
`timescale 1ns / 1ps
// IPv4 dotted-text parser, one character per request; NUL ends the string.
// A NUL goes through the input register, then the result register, onto rsp_.
// Throughput: one request per cycle; the input register and the parse state
// update in a single pass; only a NUL facing a full, stalled result register waits.
// Reset (synchronous, active high) clears phase, base, part count, error flag and
// both valid flags; part values load before they are read.
module ipv4_dotted_text_parser
   import ipv4p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_address
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_valid_res_ff, rsp_valid_res_in;
   logic [31:0] rsp_address_ff, rsp_address_in;

   logic             in_is_nul;
   logic             out_free;
   logic             advance;
   parse_result_type parse_res;

   // Only a NUL produces a result, so only a NUL needs room downstream
   assign in_is_nul = (in_char_ff == CHAR_NUL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_is_nul || out_free);
   assign req_stall = in_valid_ff && !advance;

   ipv4p_parse_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .result    (parse_res)
   );

   // Load a new request whenever the held one moves on (or none is held)
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_char_in = req_char_code;
         end
      end
   end

   // Capture the result on NUL; drop the valid flag once taken
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_valid_res_in = rsp_valid_res_ff;
      rsp_address_in   = rsp_address_ff;
      if (advance && in_is_nul) begin
         rsp_valid_in     = 1'b1;
         rsp_valid_res_in = parse_res.valid_res;
         rsp_address_in   = parse_res.address;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold unless reloaded
   always_ff @(posedge clock) begin
      in_char_ff       <= in_char_in;
      rsp_valid_res_ff <= rsp_valid_res_in;
      rsp_address_ff   <= rsp_address_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_address   = rsp_address_ff;

   a_stall_only_on_nul: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_is_nul && rsp_valid_ff)
      else $error("request stalled without a pending NUL and full result register");

   a_nul_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_is_nul |=> rsp_valid_ff)
      else $error("end of string did not produce a result");

endmodule

// ----- test/tb_ipv4_dotted_text_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_dotted_text_parser: streams address text one
// character per request and checks every result against an in-bench parser.
// Depends on ipv4p_pkg and the ipv4_dotted_text_parser RTL only.
module tb_ipv4_dotted_text_parser
   import ipv4p_pkg::*;
();

   // Timeout, well above the slowest legal run with both sides idling hard
   localparam int CYCLE_LIMIT = 200000;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_valid_res;
   logic [31:0] rsp_address;

   ipv4_dotted_text_parser uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .rsp_address   (rsp_address)
   );

   always #5 clock = ~clock;

   // Idle rates in percent, changed between test phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int chars_sent     = 0;

   // Addresses the parser must still deliver, oldest first
   parse_result_type expected_addrs[$];

   // Text of the string being built, without its terminating NUL
   logic [7:0] text_buf[$];

   // ------------------------------------------------------------------
   // In-bench parser: mirrors the block's state, one call per accepted
   // character.
   // ------------------------------------------------------------------
   phase_type   cur_phase;
   base_type    cur_base;
   logic [2:0]  part_total;
   logic [31:0] part_val[4];
   logic        string_bad;

   function automatic void clear_parse();
      cur_phase  = PH_START;
      cur_base   = BASE_DEC;
      part_total = 3'd0;
      for (int i = 0; i < 4; i++) part_val[i] = 32'd0;
      string_bad = 1'b0;
   endfunction

   function automatic logic [31:0] part_radix();
      case (cur_base)
         BASE_HEX: return 32'd16;
         BASE_OCT: return 32'd8;
         default:  return 32'd10;
      endcase
   endfunction

   // Digit value 0..15, or 16 for anything that is no hex digit
   function automatic logic [4:0] char_digit(logic [7:0] c);
      logic [7:0] off;
      off = 8'd16;
      if (c >= CHAR_0 && c <= CHAR_9) off = c - CHAR_0;
      else if (c >= CHAR_LA && c <= CHAR_LF) off = c - CHAR_LA + 8'd10;
      else if (c >= CHAR_UA && c <= CHAR_UF) off = c - CHAR_UA + 8'd10;
      return off[4:0];
   endfunction

   // Fold one digit into the current part; 0 flags an error
   function automatic logic accumulate_digit(logic [7:0] c);
      logic [2:0]  slot;
      logic [1:0]  idx;
      logic [31:0] b;
      logic [4:0]  d;
      logic [63:0] nxt;
      slot = part_total - 3'd1;
      idx  = slot[1:0];
      b    = part_radix();
      if (part_val[idx] > ALL_ONES / b) return 1'b0;
      d = char_digit(c);
      if ({27'd0, d} >= b) return 1'b0;
      nxt = {32'd0, part_val[idx]} * {32'd0, b} + {59'd0, d};
      if (nxt > {32'd0, ALL_ONES}) return 1'b0;
      part_val[idx] = nxt[31:0];
      cur_phase     = PH_DIGITS;
      return 1'b1;
   endfunction

   // Advance on one non-NUL character; 0 flags an error
   function automatic logic parse_char(logic [7:0] c);
      logic [2:0] slot;
      case (cur_phase)
         PH_START: begin
            if (part_total > 3'd3) return 1'b0;
            part_total = part_total + 3'd1;
            slot = part_total - 3'd1;
            part_val[slot[1:0]] = 32'd0;
            if (c == CHAR_0) begin
               cur_base  = BASE_OCT;
               cur_phase = PH_AFTER_ZERO;
               return 1'b1;
            end
            cur_base = BASE_DEC;
            if (c == CHAR_PERIOD) return 1'b0;
            return accumulate_digit(c);
         end
         PH_AFTER_ZERO: begin
            if (c == CHAR_LX) begin
               cur_base  = BASE_HEX;
               cur_phase = PH_AFTER_0X;
               return 1'b1;
            end
            if (c == CHAR_PERIOD) begin
               cur_phase = PH_START;
               return 1'b1;
            end
            return accumulate_digit(c);
         end
         PH_AFTER_0X: begin
            if (c == CHAR_PERIOD) return 1'b0;
            return accumulate_digit(c);
         end
         PH_DIGITS: begin
            if (c == CHAR_PERIOD) begin
               cur_phase = PH_START;
               return 1'b1;
            end
            return accumulate_digit(c);
         end
         default: return 1'b0;
      endcase
   endfunction

   // NUL: assemble the address, queue the expected result, start over
   function automatic void close_string();
      parse_result_type r;
      logic [31:0]      acc;
      logic             ok;
      int               n;
      n   = int'(part_total);
      acc = 32'd0;
      ok  = !string_bad && cur_phase != PH_START && n >= 1 && n <= 4;
      if (ok) begin
         // every part but the last is one byte, first part on top
         for (int i = 0; i < n - 1; i++) begin
            if (part_val[i] > BYTE_MAX) ok = 1'b0;
            acc |= part_val[i] << (8 * (3 - i));
         end
         // the last part fills whatever bits are left
         if (part_val[n - 1] > (ALL_ONES >> (8 * (n - 1)))) ok = 1'b0;
         acc |= part_val[n - 1];
      end
      r.valid_res = ok;
      r.address   = ok ? acc : 32'd0;
      expected_addrs.push_back(r);
      clear_parse();
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Send one character, idling at random first; predict on acceptance
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      // hold the request until the block takes it
      while (req_stall) @(posedge clock);
      chars_sent++;
      if (c == CHAR_NUL) close_string();
      else if (!string_bad) string_bad = !parse_char(c);
   endtask

   // Send the built text plus its terminating NUL, then clear the buffer
   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i]);
      send_char(CHAR_NUL);
      text_buf.delete();
   endtask

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // Append one part in the given base, with random digit case and the
   // occasional redundant leading zero
   function automatic void put_number(logic [35:0] value, base_type bt);
      logic [7:0]  digs[$];
      logic [35:0] v;
      logic [35:0] rdx;
      logic [7:0]  d;
      v   = value;
      rdx = (bt == BASE_HEX) ? 36'd16 : (bt == BASE_OCT) ? 36'd8 : 36'd10;
      while (v != 36'd0) begin
         d = 8'(v % rdx);
         if (d < 8'd10) digs.push_front(CHAR_0 + d);
         else if ($urandom_range(1)) digs.push_front(CHAR_UA + d - 8'd10);
         else digs.push_front(CHAR_LA + d - 8'd10);
         v = v / rdx;
      end
      case (bt)
         BASE_OCT: begin
            text_buf.push_back(CHAR_0);
            if ($urandom_range(7) == 0) text_buf.push_back(CHAR_0);
         end
         BASE_HEX: begin
            text_buf.push_back(CHAR_0);
            text_buf.push_back(CHAR_LX);
            if ($urandom_range(7) == 0) text_buf.push_back(CHAR_0);
         end
         default: if (value == 36'd0) text_buf.push_back(CHAR_0);
      endcase
      foreach (digs[i]) text_buf.push_back(digs[i]);
   endfunction

   // Pick a part value for a field of the given width, mostly in range,
   // with the edges and one past the top mixed in
   function automatic logic [35:0] pick_part(int bits);
      logic [35:0] lim;
      lim = (36'd1 << bits) - 36'd1;
      case ($urandom_range(19))
         0, 1:    return 36'd0;
         2, 3:    return lim;
         4:       return lim + 36'd1;
         5, 6, 7: return 36'(($urandom_range(9)));
         default: return {4'd0, $urandom()} & lim;
      endcase
   endfunction

   // Build one well-formed address string of one to four parts
   function automatic void build_address();
      int       n;
      base_type bt;
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(2))
            0:       bt = BASE_OCT;
            1:       bt = BASE_HEX;
            default: bt = BASE_DEC;
         endcase
         put_number(pick_part((i == n - 1) ? 32 - 8 * i : 8), bt);
         if (i != n - 1) text_buf.push_back(CHAR_PERIOD);
      end
   endfunction

   // ------------------------------------------------------------------
   // Response side: check every accepted result, stall at random
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_addrs.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, rsp_address);
         end else begin
            want = expected_addrs.pop_front();
            if (rsp_valid_res !== want.valid_res)
               report_mismatch("valid_res", {31'd0, want.valid_res}, {31'd0, rsp_valid_res});
            if (rsp_address !== want.address)
               report_mismatch("address", want.address, rsp_address);
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ipv4_dotted_text_parser: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Edges of the grammar, one string each
   task automatic test_directed_cases();
      send_text();                    // empty string
      put_text("0");          send_text();  // lone zero
      put_text("0x");         send_text();  // bare hex prefix, value 0
      put_text(".");          send_text();  // empty first part
      put_text("0x.");        send_text();  // empty part after hex prefix
      put_text("1.");         send_text();  // trailing period
      put_text("1.2.3.4.5");  send_text();  // fifth part
      put_text("0X1");        send_text();  // uppercase X is no prefix
      put_text("08");         send_text();  // digit too large for octal
      put_text("4294967296"); send_text();  // overflow after multiply-add
      put_text("0x100000000"); send_text(); // overflow before multiply
      put_text("0xFFffFFff"); send_text();  // full 32-bit single part
      put_text("256.1");      send_text();  // leading part above a byte
      put_text("1.0xffffff"); send_text();  // 24-bit tail at its top
      // high bytes are bad digits; the rest of the string is dropped
      put_text("7");
      text_buf.push_back(8'hff);
      text_buf.push_back(8'h80);
      put_text("1");
      send_text();
   endtask

   // Well-formed addresses with random parts, bases and sizes
   task automatic test_valid_addresses(int budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         build_address();
         send_text();
      end
   endtask

   // Well-formed addresses with one corruption each
   task automatic test_malformed_strings(int budget);
      int start;
      int pos;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         build_address();
         pos = $urandom_range(text_buf.size() - 1);
         case ($urandom_range(5))
            0: text_buf.insert($urandom_range(text_buf.size()), 8'($urandom_range(255, 1)));
            1: text_buf.delete(pos);
            2: text_buf.push_back(CHAR_PERIOD);
            3: text_buf.insert($urandom_range(text_buf.size()), CHAR_PERIOD);
            4: put_text(".1.2.3.4");
            default: text_buf[pos] = 8'($urandom_range(126, 33));
         endcase
         send_text();
      end
   endtask

   // Short strings of raw bytes, half of them drawn from hex digits, x, X and period
   task automatic test_byte_noise(int budget);
      string charset;
      int    start;
      int    len;
      charset = "0123456789abcdefABCDEFxX.";
      start   = chars_sent;
      while (chars_sent - start < budget) begin
         len = $urandom_range(10);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(1)) text_buf.push_back(charset[$urandom_range(charset.len() - 1)]);
            else text_buf.push_back(8'($urandom_range(255, 1)));
         end
         send_text();
      end
   endtask

   initial begin
      clear_parse();
      // hold reset, then release at an edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct = 84;
      test_directed_cases();

      // three passes: sender light / receiver heavy, swapped, then no idling
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 24 : (p == 1) ? 84 : 0;
         recv_idle_pct = (p == 0) ? 84 : (p == 1) ? 24 : 0;
         test_valid_addresses(150);
         test_malformed_strings(50);
         test_byte_noise(25);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then allow for the output pipeline
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_addrs.size() == 0) begin
         $display("tb_ipv4_dotted_text_parser: PASS");
      end else begin
         $display("tb_ipv4_dotted_text_parser: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/ipv4p_pkg.sv
hw/rtl/ipv4p_digit_acc.sv
hw/rtl/ipv4p_parse_fsm.sv
hw/rtl/ipv4_dotted_text_parser.sv
test/tb_ipv4_dotted_text_parser.sv
